>>> src/srpt_pkg.sv
// shared types and constants of the sorted ring peer table
`default_nettype none
package srpt_pkg;

	localparam int WRAP_MIN_MEMBERS = 2;

	localparam logic [1:0] OP_JOIN  = 2'd0;
	localparam logic [1:0] OP_LEAVE = 2'd1;
	localparam logic [1:0] OP_QUERY = 2'd2;

	localparam logic [2:0] KIND_JOINER = 3'd0;
	localparam logic [2:0] KIND_UPDATE = 3'd1;
	localparam logic [2:0] KIND_QUERY  = 3'd2;
	localparam logic [2:0] KIND_MISS   = 3'd3;
	localparam logic [2:0] KIND_FULL   = 3'd4;

	typedef struct packed {
		logic [1:0]  operation;
		logic [15:0] peer_port;
		logic [31:0] peer_address;
	} req_t;

	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] dest_port;
		logic [15:0] left_port;
		logic [15:0] right_port;
		logic        last;
	} rsp_t;

	typedef enum logic [4:0] {
		ST_IDLE, ST_J_RD, ST_J_CHK, ST_J_DEC, ST_SH_RD, ST_SH_WR, ST_INS, ST_EMIT_J,
		ST_L_AFTER, ST_L_RD, ST_L_WR, ST_L_DONE, ST_Q_EMIT, ST_N_L, ST_EMIT_NL,
		ST_N_R, ST_EMIT_NR, ST_RP_RD, ST_RP_CHK, ST_RP_NX_RD, ST_RP_NX_CHK,
		ST_RP_WRAP, ST_RP_LA_RD, ST_RP_LA_CHK
	} state_t;

	typedef enum logic [2:0] {
		E_MISS, E_FULL, E_JOIN, E_QUERY, E_UPD_L, E_UPD_R
	} emit_t;

	typedef enum logic [1:0] {
		RA_I, RA_I_M1, RA_I_P1, RA_LAST
	} raddr_sel_t;

	typedef enum logic [1:0] {
		TGT_NL, TGT_NR, TGT_PORT
	} tgt_sel_t;

	typedef struct packed {
		logic       load_in;
		logic       j_chk;
		logic       inc_i;
		logic       dec_i;
		logic       set_i_count;
		raddr_sel_t raddr_sel;
		logic       shift_wr;
		logic       ins_wr;
		logic       cnt_inc;
		logic       cnt_dec;
		logic       tgt_load;
		tgt_sel_t   tgt_sel;
		logic       rp_chk;
		logic       rp_nx_chk;
		logic       rp_la_chk;
		logic       save_nbr;
		logic       emit;
		emit_t      emit_sel;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic       i_ge_cnt;
		logic       i1_ge_cnt;
		logic       i_eq_pos;
		logic       match;
		logic       dup;
		logic       full;
		logic       found;
		logic       need_wrap;
		logic       nl_nz;
		logic       nr_nz;
		logic       out_free;
	} sts_t;

endpackage
`default_nettype wire

>>> src/srpt_dp.sv
// datapath of the peer table: storage, scan counter, neighbor registers, output register
`default_nettype none
module srpt_dp #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire srpt_pkg::req_t req,
	input  wire logic          rsp_stall,
	output logic               rsp_valid,
	output srpt_pkg::rsp_t     rsp,
	input  wire srpt_pkg::cmd_t cmd,
	output srpt_pkg::sts_t     sts
);

	localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CW = $clog2(TABLE_DEPTH + 1);

	logic [15:0] port_mem [TABLE_DEPTH];
	logic [31:0] addr_mem [TABLE_DEPTH];

	logic [15:0]   port_q, tgt_q, prev_q, first_q, l_q, r_q, nl_q, nr_q;
	logic [31:0]   addr_q;
	logic [CW-1:0] i_q, pos_q, cnt_q;
	logic          pos_found_q, dup_q, found_q;
	logic [15:0]   rd_port_q;
	logic [31:0]   rd_addr_q;
	logic          out_valid_q;
	srpt_pkg::rsp_t out_q;

	logic [CW:0]   i_p1;
	logic [CW-1:0] raddr_w;
	logic [AW-1:0] raddr;
	logic          out_free;
	srpt_pkg::rsp_t emit_d;

	assign i_p1 = {1'b0, i_q} + {{CW{1'b0}}, 1'b1};
	assign out_free = !out_valid_q || !rsp_stall;

	always_comb begin
		case (cmd.raddr_sel)
			srpt_pkg::RA_I:    raddr_w = i_q;
			srpt_pkg::RA_I_M1: raddr_w = i_q - CW'(1);
			srpt_pkg::RA_I_P1: raddr_w = i_p1[CW-1:0];
			srpt_pkg::RA_LAST: raddr_w = cnt_q - CW'(1);
			default:           raddr_w = i_q;
		endcase
		raddr = raddr_w[AW-1:0];
	end

	always_ff @(posedge clk) begin
		rd_port_q <= port_mem[raddr];
		rd_addr_q <= addr_mem[raddr];
		if (cmd.shift_wr) begin
			port_mem[i_q[AW-1:0]] <= rd_port_q;
			addr_mem[i_q[AW-1:0]] <= rd_addr_q;
		end else if (cmd.ins_wr) begin
			port_mem[pos_q[AW-1:0]] <= port_q;
			addr_mem[pos_q[AW-1:0]] <= addr_q;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			port_q <= req.peer_port;
			addr_q <= req.peer_address;
			tgt_q <= req.peer_port;
			pos_q <= cnt_q;
			pos_found_q <= 1'b0;
			dup_q <= 1'b0;
			found_q <= 1'b0;
			l_q <= '0;
			r_q <= '0;
		end
		if (cmd.tgt_load) begin
			case (cmd.tgt_sel)
				srpt_pkg::TGT_NL: tgt_q <= nl_q;
				srpt_pkg::TGT_NR: tgt_q <= nr_q;
				default:          tgt_q <= port_q;
			endcase
			found_q <= 1'b0;
			l_q <= '0;
			r_q <= '0;
		end
		if (cmd.load_in || cmd.tgt_load) begin
			i_q <= '0;
		end else if (cmd.set_i_count) begin
			i_q <= cnt_q;
		end else if (cmd.dec_i) begin
			i_q <= i_q - CW'(1);
		end else if (cmd.inc_i || (cmd.rp_chk && rd_port_q != tgt_q)) begin
			i_q <= i_p1[CW-1:0];
		end
		if (cmd.j_chk) begin
			if (rd_port_q == port_q && rd_addr_q == addr_q) begin
				dup_q <= 1'b1;
			end
			if (!pos_found_q && rd_port_q > port_q) begin
				pos_q <= i_q;
				pos_found_q <= 1'b1;
			end
		end
		if (cmd.rp_chk) begin
			if (i_q == '0) begin
				first_q <= rd_port_q;
			end
			if (rd_port_q == tgt_q) begin
				found_q <= 1'b1;
				l_q <= (i_q == '0) ? 16'd0 : prev_q;
			end else begin
				prev_q <= rd_port_q;
			end
		end
		if (cmd.rp_nx_chk) begin
			r_q <= rd_port_q;
		end
		if (cmd.rp_la_chk) begin
			if (l_q == '0) begin
				l_q <= rd_port_q;
			end
			if (r_q == '0) begin
				r_q <= first_q;
			end
		end
		if (cmd.save_nbr || (cmd.emit && out_free && cmd.emit_sel == srpt_pkg::E_JOIN)) begin
			nl_q <= l_q;
			nr_q <= r_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.cnt_inc) begin
				cnt_q <= cnt_q + CW'(1);
			end else if (cmd.cnt_dec) begin
				cnt_q <= cnt_q - CW'(1);
			end
			if (cmd.emit && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		emit_d.dest_port = port_q;
		emit_d.left_port = l_q;
		emit_d.right_port = r_q;
		emit_d.last = 1'b1;
		case (cmd.emit_sel)
			srpt_pkg::E_MISS: begin
				emit_d.kind = srpt_pkg::KIND_MISS;
				emit_d.left_port = '0;
				emit_d.right_port = '0;
			end
			srpt_pkg::E_FULL: begin
				emit_d.kind = srpt_pkg::KIND_FULL;
				emit_d.left_port = '0;
				emit_d.right_port = '0;
			end
			srpt_pkg::E_JOIN: begin
				emit_d.kind = srpt_pkg::KIND_JOINER;
				emit_d.last = (l_q == '0) && (r_q == '0);
			end
			srpt_pkg::E_QUERY: begin
				emit_d.kind = srpt_pkg::KIND_QUERY;
			end
			srpt_pkg::E_UPD_L: begin
				emit_d.kind = srpt_pkg::KIND_UPDATE;
				emit_d.dest_port = nl_q;
				emit_d.last = (nr_q == '0);
			end
			srpt_pkg::E_UPD_R: begin
				emit_d.kind = srpt_pkg::KIND_UPDATE;
				emit_d.dest_port = nr_q;
			end
			default: begin
				emit_d.kind = srpt_pkg::KIND_MISS;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.emit && out_free) begin
			out_q <= emit_d;
		end
	end

	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_comb begin
		sts.op = req.operation;
		sts.i_ge_cnt = (i_q >= cnt_q);
		sts.i1_ge_cnt = (i_p1 >= {1'b0, cnt_q});
		sts.i_eq_pos = (i_q == pos_q);
		sts.match = (rd_port_q == tgt_q);
		sts.dup = dup_q;
		sts.full = (cnt_q == CW'(TABLE_DEPTH));
		sts.found = found_q;
		sts.need_wrap = (cnt_q > CW'(srpt_pkg::WRAP_MIN_MEMBERS)) && ((l_q == '0) || (r_q == '0));
		sts.nl_nz = (nl_q != '0);
		sts.nr_nz = (nr_q != '0);
		sts.out_free = out_free;
	end

endmodule
`default_nettype wire

>>> src/srpt_ctrl.sv
// sequencer of the peer table: join, leave, query and neighbor lookup steps
`default_nettype none
module srpt_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire srpt_pkg::sts_t sts,
	output srpt_pkg::cmd_t      cmd
);

	srpt_pkg::state_t state_q, state_d, ret_q, ret_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= srpt_pkg::ST_IDLE;
			ret_q <= srpt_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
			ret_q <= ret_d;
		end
	end

	always_comb begin
		state_d = state_q;
		ret_d = ret_q;
		case (state_q)
			srpt_pkg::ST_IDLE: begin
				if (req_valid) begin
					ret_d = srpt_pkg::ST_IDLE;
					state_d = srpt_pkg::ST_IDLE;
					case (sts.op)
						srpt_pkg::OP_JOIN: state_d = srpt_pkg::ST_J_RD;
						srpt_pkg::OP_LEAVE: begin
							state_d = srpt_pkg::ST_RP_RD;
							ret_d = srpt_pkg::ST_L_AFTER;
						end
						srpt_pkg::OP_QUERY: begin
							state_d = srpt_pkg::ST_RP_RD;
							ret_d = srpt_pkg::ST_Q_EMIT;
						end
						default: state_d = srpt_pkg::ST_IDLE;
					endcase
				end
			end
			srpt_pkg::ST_J_RD:
				state_d = sts.i_ge_cnt ? srpt_pkg::ST_J_DEC : srpt_pkg::ST_J_CHK;
			srpt_pkg::ST_J_CHK: state_d = srpt_pkg::ST_J_RD;
			srpt_pkg::ST_J_DEC: begin
				if (sts.dup || sts.full) begin
					if (sts.out_free) begin
						state_d = srpt_pkg::ST_IDLE;
					end
				end else begin
					state_d = srpt_pkg::ST_SH_RD;
				end
			end
			srpt_pkg::ST_SH_RD:
				state_d = sts.i_eq_pos ? srpt_pkg::ST_INS : srpt_pkg::ST_SH_WR;
			srpt_pkg::ST_SH_WR: state_d = srpt_pkg::ST_SH_RD;
			srpt_pkg::ST_INS: begin
				state_d = srpt_pkg::ST_RP_RD;
				ret_d = srpt_pkg::ST_EMIT_J;
			end
			srpt_pkg::ST_EMIT_J: if (sts.out_free) state_d = srpt_pkg::ST_N_L;
			srpt_pkg::ST_L_AFTER: begin
				if (sts.found) begin
					state_d = srpt_pkg::ST_L_RD;
				end else if (sts.out_free) begin
					state_d = srpt_pkg::ST_IDLE;
				end
			end
			srpt_pkg::ST_L_RD:
				state_d = sts.i1_ge_cnt ? srpt_pkg::ST_L_DONE : srpt_pkg::ST_L_WR;
			srpt_pkg::ST_L_WR: state_d = srpt_pkg::ST_L_RD;
			srpt_pkg::ST_L_DONE: state_d = srpt_pkg::ST_N_L;
			srpt_pkg::ST_Q_EMIT: if (sts.out_free) state_d = srpt_pkg::ST_IDLE;
			srpt_pkg::ST_N_L: begin
				if (sts.nl_nz) begin
					state_d = srpt_pkg::ST_RP_RD;
					ret_d = srpt_pkg::ST_EMIT_NL;
				end else begin
					state_d = srpt_pkg::ST_N_R;
				end
			end
			srpt_pkg::ST_EMIT_NL: if (sts.out_free) state_d = srpt_pkg::ST_N_R;
			srpt_pkg::ST_N_R: begin
				if (sts.nr_nz) begin
					state_d = srpt_pkg::ST_RP_RD;
					ret_d = srpt_pkg::ST_EMIT_NR;
				end else begin
					state_d = srpt_pkg::ST_IDLE;
				end
			end
			srpt_pkg::ST_EMIT_NR: if (sts.out_free) state_d = srpt_pkg::ST_IDLE;
			srpt_pkg::ST_RP_RD:
				state_d = sts.i_ge_cnt ? srpt_pkg::ST_RP_WRAP : srpt_pkg::ST_RP_CHK;
			srpt_pkg::ST_RP_CHK: begin
				if (sts.match) begin
					state_d = sts.i1_ge_cnt ? srpt_pkg::ST_RP_WRAP : srpt_pkg::ST_RP_NX_RD;
				end else begin
					state_d = srpt_pkg::ST_RP_RD;
				end
			end
			srpt_pkg::ST_RP_NX_RD: state_d = srpt_pkg::ST_RP_NX_CHK;
			srpt_pkg::ST_RP_NX_CHK: state_d = srpt_pkg::ST_RP_WRAP;
			srpt_pkg::ST_RP_WRAP:
				state_d = sts.need_wrap ? srpt_pkg::ST_RP_LA_RD : ret_q;
			srpt_pkg::ST_RP_LA_RD: state_d = srpt_pkg::ST_RP_LA_CHK;
			srpt_pkg::ST_RP_LA_CHK: state_d = ret_q;
			default: state_d = srpt_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.raddr_sel = srpt_pkg::RA_I;
		cmd.tgt_sel = srpt_pkg::TGT_PORT;
		cmd.emit_sel = srpt_pkg::E_MISS;
		req_stall = (state_q != srpt_pkg::ST_IDLE);
		case (state_q)
			srpt_pkg::ST_IDLE: cmd.load_in = req_valid;
			srpt_pkg::ST_J_CHK: begin
				cmd.j_chk = 1'b1;
				cmd.inc_i = 1'b1;
			end
			srpt_pkg::ST_J_DEC: begin
				if (sts.dup) begin
					cmd.emit = 1'b1;
				end else if (sts.full) begin
					cmd.emit = 1'b1;
					cmd.emit_sel = srpt_pkg::E_FULL;
				end else begin
					cmd.set_i_count = 1'b1;
				end
			end
			srpt_pkg::ST_SH_RD: cmd.raddr_sel = srpt_pkg::RA_I_M1;
			srpt_pkg::ST_SH_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.dec_i = 1'b1;
			end
			srpt_pkg::ST_INS: begin
				cmd.ins_wr = 1'b1;
				cmd.cnt_inc = 1'b1;
				cmd.tgt_load = 1'b1;
			end
			srpt_pkg::ST_EMIT_J: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = srpt_pkg::E_JOIN;
			end
			srpt_pkg::ST_L_AFTER: begin
				if (sts.found) begin
					cmd.save_nbr = 1'b1;
				end else begin
					cmd.emit = 1'b1;
				end
			end
			srpt_pkg::ST_L_RD: cmd.raddr_sel = srpt_pkg::RA_I_P1;
			srpt_pkg::ST_L_WR: begin
				cmd.shift_wr = 1'b1;
				cmd.inc_i = 1'b1;
			end
			srpt_pkg::ST_L_DONE: cmd.cnt_dec = 1'b1;
			srpt_pkg::ST_Q_EMIT: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = sts.found ? srpt_pkg::E_QUERY : srpt_pkg::E_MISS;
			end
			srpt_pkg::ST_N_L: begin
				cmd.tgt_load = sts.nl_nz;
				cmd.tgt_sel = srpt_pkg::TGT_NL;
			end
			srpt_pkg::ST_EMIT_NL: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = srpt_pkg::E_UPD_L;
			end
			srpt_pkg::ST_N_R: begin
				cmd.tgt_load = sts.nr_nz;
				cmd.tgt_sel = srpt_pkg::TGT_NR;
			end
			srpt_pkg::ST_EMIT_NR: begin
				cmd.emit = 1'b1;
				cmd.emit_sel = srpt_pkg::E_UPD_R;
			end
			srpt_pkg::ST_RP_CHK: cmd.rp_chk = 1'b1;
			srpt_pkg::ST_RP_NX_RD: cmd.raddr_sel = srpt_pkg::RA_I_P1;
			srpt_pkg::ST_RP_NX_CHK: cmd.rp_nx_chk = 1'b1;
			srpt_pkg::ST_RP_LA_RD: cmd.raddr_sel = srpt_pkg::RA_LAST;
			srpt_pkg::ST_RP_LA_CHK: cmd.rp_la_chk = 1'b1;
			default: cmd.raddr_sel = srpt_pkg::RA_I;
		endcase
	end

endmodule
`default_nettype wire

>>> src/sorted_ring_peer_table_top.sv
// top level of the sorted ring peer table
// The req channel carries one membership event per transfer: join, leave or
// neighbor query, with the peer's port and address. The rsp channel carries
// the neighbor messages caused by it, up to three, the final one marked last.
// Both channels transfer when valid is high and stall is low.
// The table sits in one memory with a single registered read port, so every
// step is a read followed by a compare. A query scans the table from the
// start up to the port and reads the last entry as well when the ring wraps;
// a join scans the whole table, shifts the entries above the new one and
// then runs up to three neighbor lookups; a leave shifts the entries above
// the leaving one and runs up to two lookups.
// req_stall is high from the accepted event until its last result has gone
// into the output register; a stalled rsp holds and holds back the sequencer.
// Reset empties the table at once by clearing the member count; no sweep of
// the memory is needed. Unused operation codes are taken and ignored.
`default_nettype none
module sorted_ring_peer_table_top #(
	parameter int TABLE_DEPTH = 64
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire srpt_pkg::req_t req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output srpt_pkg::rsp_t      rsp
);

	srpt_pkg::cmd_t cmd;
	srpt_pkg::sts_t sts;

	srpt_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.sts       (sts),
		.cmd       (cmd)
	);

	srpt_dp #(
		.TABLE_DEPTH (TABLE_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.rsp_stall (rsp_stall),
		.rsp_valid (rsp_valid),
		.rsp       (rsp),
		.cmd       (cmd),
		.sts       (sts)
	);

endmodule
`default_nettype wire

>>> tb/sorted_ring_peer_table_top_test.sv
// testbench for the sorted ring peer table: random membership traffic checked against a predictor
`default_nettype none
module sorted_ring_peer_table_top_test;

	localparam int DEPTH = 64;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	srpt_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	srpt_pkg::rsp_t rsp;

	sorted_ring_peer_table_top #(.TABLE_DEPTH(DEPTH)) u_top (
		.clk(clk), .arst_n(arst_n),
		.req_valid(req_valid), .req_stall(req_stall), .req(req),
		.rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp(rsp)
	);

	always #4 clk = ~clk;

	// predictor state
	logic [15:0] tbl_port [DEPTH];
	logic [31:0] tbl_addr [DEPTH];
	int member_cnt;

	srpt_pkg::req_t pending_reqs [$];
	srpt_pkg::rsp_t expected_msgs [$];
	int errors = 0;
	int send_idle_pct = 6;
	int recv_idle_pct = 59;
	int hold_cycles = 0;
	bit pause_send = 1'b0;
	bit stim_done = 1'b0;

	function automatic int find_port(logic [15:0] p);
		for (int i = 0; i < member_cnt; i++)
			if (tbl_port[i] == p) return i;
		return member_cnt;
	endfunction

	function automatic void ring_of(logic [15:0] p, output logic [15:0] l, output logic [15:0] r);
		int idx;
		idx = find_port(p);
		l = '0;
		r = '0;
		if (idx < member_cnt) begin
			if (idx > 0) l = tbl_port[idx-1];
			if (idx + 1 < member_cnt) r = tbl_port[idx+1];
		end
		if (member_cnt > srpt_pkg::WRAP_MIN_MEMBERS) begin
			if (l == 0) l = tbl_port[member_cnt-1];
			if (r == 0) r = tbl_port[0];
		end
	endfunction

	function automatic void push_msg(logic [2:0] k, logic [15:0] d, logic [15:0] l,
			logic [15:0] r);
		srpt_pkg::rsp_t m;
		m.kind = k;
		m.dest_port = d;
		m.left_port = l;
		m.right_port = r;
		m.last = 1'b0;
		expected_msgs.push_back(m);
	endfunction

	function automatic void notify(logic [15:0] l, logic [15:0] r);
		logic [15:0] a, b;
		if (l != 0) begin
			ring_of(l, a, b);
			push_msg(srpt_pkg::KIND_UPDATE, l, a, b);
		end
		if (r != 0) begin
			ring_of(r, a, b);
			push_msg(srpt_pkg::KIND_UPDATE, r, a, b);
		end
	endfunction

	function automatic void predict_event(srpt_pkg::req_t it);
		int n0, pos;
		bit dup;
		logic [15:0] l, r;
		n0 = expected_msgs.size();
		dup = 1'b0;
		if (it.operation == srpt_pkg::OP_JOIN) begin
			for (int i = 0; i < member_cnt; i++)
				if (tbl_port[i] == it.peer_port && tbl_addr[i] == it.peer_address) dup = 1'b1;
			if (dup) push_msg(srpt_pkg::KIND_MISS, it.peer_port, 16'd0, 16'd0);
			else if (member_cnt >= DEPTH)
				push_msg(srpt_pkg::KIND_FULL, it.peer_port, 16'd0, 16'd0);
			else begin
				pos = 0;
				while (pos < member_cnt && tbl_port[pos] <= it.peer_port) pos++;
				for (int i = member_cnt; i > pos; i--) begin
					tbl_port[i] = tbl_port[i-1];
					tbl_addr[i] = tbl_addr[i-1];
				end
				tbl_port[pos] = it.peer_port;
				tbl_addr[pos] = it.peer_address;
				member_cnt++;
				ring_of(it.peer_port, l, r);
				push_msg(srpt_pkg::KIND_JOINER, it.peer_port, l, r);
				notify(l, r);
			end
		end else if (it.operation == srpt_pkg::OP_LEAVE || it.operation == srpt_pkg::OP_QUERY) begin
			pos = find_port(it.peer_port);
			if (pos >= member_cnt) push_msg(srpt_pkg::KIND_MISS, it.peer_port, 16'd0, 16'd0);
			else begin
				ring_of(it.peer_port, l, r);
				if (it.operation == srpt_pkg::OP_QUERY)
					push_msg(srpt_pkg::KIND_QUERY, it.peer_port, l, r);
				else begin
					for (int i = pos; i + 1 < member_cnt; i++) begin
						tbl_port[i] = tbl_port[i+1];
						tbl_addr[i] = tbl_addr[i+1];
					end
					member_cnt--;
					notify(l, r);
				end
			end
		end
		if (expected_msgs.size() > n0) expected_msgs[expected_msgs.size()-1].last = 1'b1;
	endfunction

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
		end else begin
			if (req_valid && !req_stall) predict_event(req);
			if (!req_valid || !req_stall) begin
				if (pending_reqs.size() > 0 && !pause_send
						&& $urandom_range(99) >= send_idle_pct) begin
					req_valid <= 1'b1;
					req <= pending_reqs.pop_front();
				end else begin
					req_valid <= 1'b0;
				end
			end
		end
	end

	// receiver stall
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else if (hold_cycles > 0) begin
			rsp_stall <= 1'b1;
			hold_cycles <= hold_cycles - 1;
		end else begin
			rsp_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		srpt_pkg::rsp_t e;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (expected_msgs.size() == 0) begin
				$error("unexpected transfer kind=%0d dest=%0d", rsp.kind, rsp.dest_port);
				errors++;
			end else begin
				e = expected_msgs.pop_front();
				if (rsp.kind !== e.kind) begin
					$error("kind expected %0d actual %0d", e.kind, rsp.kind);
					errors++;
				end
				if (rsp.dest_port !== e.dest_port) begin
					$error("dest_port expected %0d actual %0d", e.dest_port, rsp.dest_port);
					errors++;
				end
				if (rsp.left_port !== e.left_port) begin
					$error("left_port expected %0d actual %0d", e.left_port, rsp.left_port);
					errors++;
				end
				if (rsp.right_port !== e.right_port) begin
					$error("right_port expected %0d actual %0d", e.right_port, rsp.right_port);
					errors++;
				end
				if (rsp.last !== e.last) begin
					$error("last expected %0d actual %0d", e.last, rsp.last);
					errors++;
				end
			end
		end
	end

	function automatic srpt_pkg::req_t mk(logic [1:0] op, logic [15:0] p, logic [31:0] a);
		srpt_pkg::req_t it;
		it.operation = op;
		it.peer_port = p;
		it.peer_address = a;
		return it;
	endfunction

	logic [15:0] used_ports [$];

	function automatic logic [15:0] pick_port();
		if (used_ports.size() > 0 && $urandom_range(99) < 70)
			return used_ports[$urandom_range(used_ports.size()-1)];
		return (16'($urandom_range(65535)));
	endfunction

	function automatic void add_random(int count);
		logic [15:0] p;
		int r;
		for (int i = 0; i < count; i++) begin
			p = pick_port();
			r = $urandom_range(99);
			if (r < 45) begin
				used_ports.push_back(p);
				pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, p, $urandom()));
			end else if (r < 70) pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, p, $urandom()));
			else if (r < 97) pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, p, $urandom()));
			else pending_reqs.push_back(mk(2'd3, p, $urandom()));
		end
	endfunction

	task automatic drain();
		while (pending_reqs.size() > 0 || req_valid || expected_msgs.size() > 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < 11; i++) @(posedge clk);
		arst_n <= 1'b1;
		member_cnt = 0;
		// directed: empty queries, extremes, duplicates, wrap, unused code
		pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, 16'd1, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'hFFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'd500, 32'h0A00_0001));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'd500, 32'h0A00_0001));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'd500, 32'h0A00_0002));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'hFFFF, 32'hFFFF_FFFF));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'd1, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'd0, 32'h5555_AAAA));
		pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, 16'd0, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, 16'd500, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, 16'hFFFF, 32'd0));
		pending_reqs.push_back(mk(2'd3, 16'd500, 32'hAAAA_5555));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'd500, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'd0, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'd1, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'd500, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'hFFFF, 32'd0));
		pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE, 16'd7, 32'd0));
		drain();
		// fill the table until full, then probe and empty part of it
		for (int i = 0; i < DEPTH + 2; i++)
			pending_reqs.push_back(mk(srpt_pkg::OP_JOIN, 16'($urandom_range(65535)), $urandom()));
		pending_reqs.push_back(mk(srpt_pkg::OP_QUERY, 16'd0, 32'd0));
		drain();
		for (int i = 0; i < 20; i++)
			pending_reqs.push_back(mk(srpt_pkg::OP_LEAVE,
				tbl_port[$urandom_range(member_cnt-1)], 32'd0));
		drain();
		add_random(35);
		hold_cycles = 400;
		drain();
		pause_send = 1'b1;
		drain();
		pause_send = 1'b0;
		send_idle_pct = 59;
		recv_idle_pct = 6;
		add_random(30);
		drain();
		send_idle_pct = 0;
		recv_idle_pct = 0;
		add_random(30);
		drain();
		for (int i = 0; i < 50; i++) @(posedge clk);
		if (errors == 0 && expected_msgs.size() == 0)
			$display("sorted_ring_peer_table_top: match");
		else begin
			if (expected_msgs.size() > 0) $error("%0d results never arrived", expected_msgs.size());
			$display("sorted_ring_peer_table_top: mismatch");
		end
		$finish;
	end

	initial begin
		#20000000;
		$display("sorted_ring_peer_table_top: mismatch");
		$finish;
	end
endmodule
`default_nettype wire
